/* rtl/mdd_pkg.sv */
// Package for the magnetic detumble dipole block: widths, codes, command
// and status types shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package mdd_pkg;

    localparam int VecW   = 16;
    localparam int GainW  = 32;
    localparam int LimW   = 24;
    localparam int DipW   = 25;
    localparam int MagW   = 32;
    localparam int CrossW = 33;
    localparam int ProdW  = 64;
    localparam int DvdW   = 56;
    localparam int DenW   = 32;
    localparam int DivCntW = 6;
    localparam int DenShift = 20;
    localparam int ShW    = 5;

    localparam logic [1:0] MODE_RATE  = 2'd0;
    localparam logic [1:0] MODE_FIELD = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic CFG_GAIN  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [GainW-1:0] GAIN_RST  = 32'd20793;
    localparam logic [LimW-1:0]  LIMIT_RST = 24'd131072;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_W,
        OP_LOAD_B,
        OP_TICK,
        OP_MUL_BSQ,
        OP_MUL_CROSS,
        OP_MUL_MSQ,
        OP_MUL_CSQ,
        OP_SET_LSAT,
        OP_NORM_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_MUL_NUM,
        OP_DIV_START,
        OP_SAVE_MM,
        OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
        logic       term;
        logic       phase;
    } t_cmd;

    typedef struct packed {
        logic both_seen;
        logic bsq_zero;
        logic sat;
        logic norm_done;
        logic div_done;
    } t_status;

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic logic [1:0] prv3(input logic [1:0] i);
        return (i == 2'd0) ? 2'd2 : i - 2'd1;
    endfunction

endpackage

`default_nettype wire

/* rtl/magnetic_detumble_dipole_law.sv */
// Top level of the magnetic detumble dipole block: streaming ports,
// config port, controller and datapath. Depends on mdd_pkg, mdd_ctrl, mdd_dp.
//
// Rate and field items (tuser 0 and 1) are stored as they arrive. A tick
// (tuser 2) after both vectors have arrived yields one dipole item; other
// ticks and tuser 3 yield nothing. A zero field skips the divides. Otherwise
// the work is set by the bit-serial divider (per component: product, start,
// 56 divide steps and a done step; three components); clamping adds the
// normalize loop, a square root and three more divides.
// One item is in work at a time; a finished dipole waits in the output
// register while input items are accepted.
`default_nettype none

module magnetic_detumble_dipole_law (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,  // vec_x, vec_y, vec_z
    input  wire logic [1:0]  i_s_axis_tuser,  // mode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,  // dipole_x, dipole_y, dipole_z, zero pad
    output logic [1:0]       o_m_axis_tuser,  // saturated, field_zero
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import mdd_pkg::*;

    t_cmd                   cmd;
    t_status                status;
    logic signed [DipW-1:0] dx, dy, dz;
    logic                   sat, fz;

    mdd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_mode    (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    mdd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_vec_x      (i_s_axis_tdata[15:0]),
        .i_vec_y      (i_s_axis_tdata[31:16]),
        .i_vec_z      (i_s_axis_tdata[47:32]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_status     (status),
        .o_dipole_x   (dx),
        .o_dipole_y   (dy),
        .o_dipole_z   (dz),
        .o_saturated  (sat),
        .o_field_zero (fz)
    );

    assign o_m_axis_tdata = {5'b0, dz, dy, dx};
    assign o_m_axis_tuser = {fz, sat};

`ifndef SYNTHESIS
    a_zero_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata == '0 && !o_m_axis_tuser[0])
        else $error("zero field item carries a dipole or saturation");
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_DIV_START |-> !o_s_axis_tready)
        else $error("input ready while divider starts");
`endif

endmodule

`default_nettype wire

/* rtl/mdd_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on mdd_pkg.
`default_nettype none

module mdd_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [mdd_pkg::DvdW-1:0]   i_dividend,
    input  wire logic [mdd_pkg::DenW-1:0]   i_divisor,
    output logic                            o_done,
    output logic [mdd_pkg::DvdW-1:0]        o_quot
);
    import mdd_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [DivCntW-1:0] r_cnt;
    logic [DenW-1:0]    r_rem;
    logic [DenW-1:0]    r_dsr;
    logic [DvdW-1:0]    r_dvd;
    logic [DvdW-1:0]    r_q;
    logic [DenW:0]      trial;
    logic [DenW:0]      diff;
    logic               ge;

    always_comb begin
        trial = {r_rem, r_dvd[DvdW-1]};
        ge    = trial >= {1'b0, r_dsr};
        diff  = trial - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DivCntW'(DvdW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
            r_q   <= {r_q[DvdW-2:0], ge};
            r_dvd <= {r_dvd[DvdW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

/* rtl/mdd_dp.sv */
// Datapath: stored vectors, config registers, shared multiplier, square root
// steps and the divider. Depends on mdd_pkg and mdd_div.
`default_nettype none

module mdd_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire mdd_pkg::t_cmd                     i_cmd,
    input  wire logic signed [mdd_pkg::VecW-1:0]   i_vec_x,
    input  wire logic signed [mdd_pkg::VecW-1:0]   i_vec_y,
    input  wire logic signed [mdd_pkg::VecW-1:0]   i_vec_z,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [mdd_pkg::GainW-1:0]         i_cfg_data,
    output mdd_pkg::t_status                       o_status,
    output logic signed [mdd_pkg::DipW-1:0]        o_dipole_x,
    output logic signed [mdd_pkg::DipW-1:0]        o_dipole_y,
    output logic signed [mdd_pkg::DipW-1:0]        o_dipole_z,
    output logic                                   o_saturated,
    output logic                                   o_field_zero
);
    import mdd_pkg::*;

    logic [GainW-1:0]         r_gain;
    logic [LimW-1:0]          r_limit;
    logic signed [VecW-1:0]   r_w [3];
    logic signed [VecW-1:0]   r_b [3];
    logic                     r_rate_seen;
    logic                     r_field_seen;
    logic                     r_sat;
    logic [ProdW-1:0]         r_acc;
    logic [DenW-1:0]          r_bsq;
    logic signed [CrossW-1:0] r_c [3];
    logic [ProdW-1:0]         r_num;
    logic [LimW-1:0]          r_mm [3];
    logic [ShW-1:0]           r_sh;
    logic [ProdW-1:0]         r_sx;
    logic [ProdW-1:0]         r_res;
    logic [ProdW-1:0]         r_bit;
    logic signed [DipW-1:0]   r_dx, r_dy, r_dz;
    logic                     r_osat, r_ofz;

    logic [MagW-1:0]          cm [3];
    logic signed [CrossW-1:0] neg_c [3];
    logic                     cpos [3];
    logic signed [DipW-1:0]   dip [3];
    logic [MagW-1:0]          mul_a, mul_b;
    logic [ProdW-1:0]         prod;
    logic [ProdW-1:0]         acc_sum;
    logic signed [CrossW-1:0] term_v;
    logic                     term_neg;
    logic [ProdW-1:0]         trial;
    logic                     sq_ge;
    logic [ProdW-1:0]         cm_sh;
    logic [DenW-1:0]          qs;
    logic [DvdW-1:0]          dvd;
    logic [DenW-1:0]          dsr;
    logic                     div_done;
    logic [DvdW-1:0]          quot;
    logic                     fz;

    function automatic logic [MagW-1:0] mag16(input logic signed [VecW-1:0] v);
        logic signed [VecW:0] e;
        e = {v[VecW-1], v};
        if (e < 0) e = -e;
        return {{(MagW-VecW-1){1'b0}}, e};
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg_c[i] = -r_c[i];
            cm[i]    = r_c[i][CrossW-1] ? neg_c[i][MagW-1:0] : r_c[i][MagW-1:0];
            cpos[i]  = !r_c[i][CrossW-1] && (r_c[i] != '0);
            dip[i]   = cpos[i] ? -$signed({1'b0, r_mm[i]}) : $signed({1'b0, r_mm[i]});
        end
        cm_sh    = {{(ProdW-MagW){1'b0}}, cm[i_cmd.idx]} << r_sh;
        mul_a    = '0;
        mul_b    = '0;
        term_neg = 1'b0;
        case (i_cmd.op)
            OP_MUL_BSQ: begin
                mul_a = mag16(r_b[i_cmd.idx]);
                mul_b = mul_a;
            end
            OP_MUL_CROSS: begin
                if (!i_cmd.term) begin
                    mul_a    = mag16(r_b[nxt3(i_cmd.idx)]);
                    mul_b    = mag16(r_w[prv3(i_cmd.idx)]);
                    term_neg = r_b[nxt3(i_cmd.idx)][VecW-1] ^ r_w[prv3(i_cmd.idx)][VecW-1];
                end else begin
                    mul_a    = mag16(r_b[prv3(i_cmd.idx)]);
                    mul_b    = mag16(r_w[nxt3(i_cmd.idx)]);
                    term_neg = !(r_b[prv3(i_cmd.idx)][VecW-1] ^
                                 r_w[nxt3(i_cmd.idx)][VecW-1]);
                end
            end
            OP_MUL_MSQ: begin
                mul_a = {{(MagW-LimW){1'b0}}, r_mm[i_cmd.idx]};
                mul_b = mul_a;
            end
            OP_MUL_CSQ: begin
                mul_a = cm[i_cmd.idx];
                mul_b = mul_a;
            end
            OP_SET_LSAT: begin
                mul_a = {{(MagW-LimW){1'b0}}, r_limit};
                mul_b = mul_a;
            end
            OP_MUL_NUM: begin
                if (!i_cmd.phase) begin
                    mul_a = r_gain;
                    mul_b = cm[i_cmd.idx];
                end else begin
                    mul_a = cm_sh[MagW-1:0];
                    mul_b = {{(MagW-LimW){1'b0}}, r_limit};
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod    = {{(ProdW-MagW){1'b0}}, mul_a} * {{(ProdW-MagW){1'b0}}, mul_b};
        acc_sum = ((i_cmd.idx == 2'd0) ? '0 : r_acc) + prod;
        term_v  = term_neg ? -$signed({1'b0, prod[MagW-1:0]})
                           : $signed({1'b0, prod[MagW-1:0]});
        trial   = r_res + r_bit;
        sq_ge   = r_sx >= trial;
        qs      = (r_res == '0) ? DenW'(1) : r_res[DenW-1:0];
        dvd     = i_cmd.phase ? r_num[DvdW-1:0]
                              : {{(DvdW-ProdW+DenShift){1'b0}}, r_num[ProdW-1:DenShift]};
        dsr     = i_cmd.phase ? qs : r_bsq;
        fz      = (r_bsq == '0);
    end

    mdd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_START),
        .i_dividend (dvd),
        .i_divisor  (dsr),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= GAIN_RST;
            r_limit      <= LIMIT_RST;
            r_rate_seen  <= 1'b0;
            r_field_seen <= 1'b0;
            r_sat        <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_w[i] <= '0;
                r_b[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GAIN) r_gain <= i_cfg_data;
                else r_limit <= i_cfg_data[LimW-1:0];
            end
            case (i_cmd.op)
                OP_LOAD_W: begin
                    r_w[0] <= i_vec_x;
                    r_w[1] <= i_vec_y;
                    r_w[2] <= i_vec_z;
                    r_rate_seen <= 1'b1;
                end
                OP_LOAD_B: begin
                    r_b[0] <= i_vec_x;
                    r_b[1] <= i_vec_y;
                    r_b[2] <= i_vec_z;
                    r_field_seen <= 1'b1;
                end
                OP_TICK:     r_sat <= 1'b0;
                OP_SET_LSAT: r_sat <= r_acc > prod;
                OP_SAVE_MM: begin
                    if (!i_cmd.phase && (quot[DvdW-1:LimW] != '0)) r_sat <= 1'b1;
                end
                default: r_sat <= r_sat;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MUL_BSQ: begin
                r_acc <= acc_sum;
                r_bsq <= acc_sum[DenW-1:0];
            end
            OP_MUL_CROSS: r_c[i_cmd.idx] <= (i_cmd.term ? r_c[i_cmd.idx] : '0) + term_v;
            OP_MUL_MSQ:   r_acc <= acc_sum;
            OP_MUL_CSQ: begin
                r_acc <= acc_sum;
                if (i_cmd.idx == 2'd0) r_sh <= '0;
            end
            OP_NORM_STEP: begin
                r_acc <= {r_acc[ProdW-3:0], 2'b00};
                r_sh  <= r_sh + 1'b1;
            end
            OP_SQRT_INIT: begin
                r_sx  <= r_acc;
                r_res <= '0;
                r_bit <= {2'b01, {(ProdW-2){1'b0}}};
            end
            OP_SQRT_STEP: begin
                if (sq_ge) begin
                    r_sx  <= r_sx - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_MUL_NUM: r_num <= prod;
            OP_SAVE_MM: r_mm[i_cmd.idx] <= quot[LimW-1:0];
            OP_OUT_LOAD: begin
                r_dx   <= fz ? '0 : dip[0];
                r_dy   <= fz ? '0 : dip[1];
                r_dz   <= fz ? '0 : dip[2];
                r_osat <= !fz && r_sat;
                r_ofz  <= fz;
            end
            default: r_num <= r_num;
        endcase
    end

    assign o_status.both_seen = r_rate_seen && r_field_seen;
    assign o_status.bsq_zero  = fz;
    assign o_status.sat       = r_sat;
    assign o_status.norm_done = (r_sh == '1) || (r_acc[ProdW-1:ProdW-2] != 2'b00);
    assign o_status.div_done  = div_done;
    assign o_dipole_x   = r_dx;
    assign o_dipole_y   = r_dy;
    assign o_dipole_z   = r_dz;
    assign o_saturated  = r_osat;
    assign o_field_zero = r_ofz;

endmodule

`default_nettype wire

/* rtl/mdd_ctrl.sv */
// Controller: sequences the datapath through one dipole computation per tick
// and owns both handshakes. Depends on mdd_pkg.
`default_nettype none

module mdd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    input  wire logic [1:0]        i_mode,
    output logic                   o_s_ready,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    input  wire mdd_pkg::t_status  i_status,
    output mdd_pkg::t_cmd          o_cmd
);
    import mdd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_BSQ, S_ZCHK, S_CROSS, S_MUL, S_DIVS, S_DIV_RUN, S_SATCHK,
        S_MSQ, S_LCMP, S_LCHK, S_CSQ, S_NORM, S_SQ_INIT, S_SQRT, S_FINISH
    } t_state;

    t_state     r_state;
    logic [4:0] r_k;
    logic [1:0] r_i;
    logic       r_phase;
    logic       r_out_valid;
    logic       take;

    assign take = !r_out_valid || i_m_ready;

    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.idx   = r_i;
        o_cmd.term  = 1'b0;
        o_cmd.phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    case (i_mode)
                        MODE_RATE:  o_cmd.op = OP_LOAD_W;
                        MODE_FIELD: o_cmd.op = OP_LOAD_B;
                        MODE_TICK:  o_cmd.op = i_status.both_seen ? OP_TICK : OP_NONE;
                        default:    o_cmd.op = OP_NONE;
                    endcase
                end
            end
            S_BSQ: begin
                o_cmd.op  = OP_MUL_BSQ;
                o_cmd.idx = r_k[1:0];
            end
            S_CROSS: begin
                o_cmd.op   = OP_MUL_CROSS;
                o_cmd.idx  = r_k[2:1];
                o_cmd.term = r_k[0];
            end
            S_MSQ: begin
                o_cmd.op  = OP_MUL_MSQ;
                o_cmd.idx = r_k[1:0];
            end
            S_CSQ: begin
                o_cmd.op  = OP_MUL_CSQ;
                o_cmd.idx = r_k[1:0];
            end
            S_LCMP:    o_cmd.op = OP_SET_LSAT;
            S_NORM:    o_cmd.op = i_status.norm_done ? OP_NONE : OP_NORM_STEP;
            S_SQ_INIT: o_cmd.op = OP_SQRT_INIT;
            S_SQRT:    o_cmd.op = OP_SQRT_STEP;
            S_MUL:     o_cmd.op = OP_MUL_NUM;
            S_DIVS:    o_cmd.op = OP_DIV_START;
            S_DIV_RUN: o_cmd.op = i_status.div_done ? OP_SAVE_MM : OP_NONE;
            S_FINISH:  o_cmd.op = take ? OP_OUT_LOAD : OP_NONE;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_i         <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FINISH && take) r_out_valid <= 1'b1;
            else if (i_m_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_s_valid && i_mode == MODE_TICK && i_status.both_seen) begin
                        r_state <= S_BSQ;
                        r_k     <= '0;
                    end
                end
                S_BSQ: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 5'd2) r_state <= S_ZCHK;
                end
                S_ZCHK: begin
                    r_k     <= '0;
                    r_state <= i_status.bsq_zero ? S_FINISH : S_CROSS;
                end
                S_CROSS: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 5'd5) begin
                        r_state <= S_MUL;
                        r_i     <= '0;
                        r_phase <= 1'b0;
                    end
                end
                S_MUL:  r_state <= S_DIVS;
                S_DIVS: r_state <= S_DIV_RUN;
                S_DIV_RUN: begin
                    if (i_status.div_done) begin
                        if (r_i == 2'd2) begin
                            r_state <= r_phase ? S_FINISH : S_SATCHK;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_SATCHK: begin
                    r_k     <= '0;
                    r_state <= i_status.sat ? S_CSQ : S_MSQ;
                end
                S_MSQ: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 5'd2) r_state <= S_LCMP;
                end
                S_LCMP: r_state <= S_LCHK;
                S_LCHK: begin
                    r_k     <= '0;
                    r_state <= i_status.sat ? S_CSQ : S_FINISH;
                end
                S_CSQ: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 5'd2) r_state <= S_NORM;
                end
                S_NORM: begin
                    if (i_status.norm_done) r_state <= S_SQ_INIT;
                end
                S_SQ_INIT: begin
                    r_k     <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 5'd31) begin
                        r_state <= S_MUL;
                        r_i     <= '0;
                        r_phase <= 1'b1;
                    end
                end
                S_FINISH: begin
                    if (take) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

endmodule

`default_nettype wire
